// ===== hdl/stable_priority_queue_core_macros.svh =====
// Assertion macros used by the checker file of the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define SPQ_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, clk, expr, msg) \
    label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Shared types and codes of the stable priority queue.
package spq_pkg;

    // Operation codes of an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_SERVED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // Fixed field widths of the ports.
    localparam int TAG_PORT_W  = 16;
    localparam int PRIO_W      = 2;
    localparam int LEN_PORT_W  = 5;

    typedef struct packed {
        logic                  op;
        logic [TAG_PORT_W-1:0] entry_tag;
        logic [PRIO_W-1:0]     entry_priority;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [TAG_PORT_W-1:0] served_tag;
        logic [PRIO_W-1:0]     served_priority;
        logic [LEN_PORT_W-1:0] queue_length;
        logic [LEN_PORT_W-1:0] peak_length;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SRV_RD,
        S_SRV_CMP,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch a new item and its early status
        logic rd_en;      // issue a slot read
        logic rd_tail;    // read slot j-1 instead of the head
        logic wr_new;     // write the new entry at slot j
        logic wr_move;    // write the slot just read at slot j
        logic step_down;  // j <= j - 1
        logic push;       // count up, track the peak
        logic pop;        // capture head, advance head, count down
        logic publish;    // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_serve;   // item on the input is a serve
        logic full;
        logic empty;
        logic j_zero;     // insert walk has reached the head
        logic lower;      // slot read holds a lower priority than the new entry
    } t_dp_stat;

endpackage

// ===== hdl/spq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module spq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/spq_ctrl.sv =====
// Controller state machine of the stable priority queue.
module spq_ctrl import spq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic     i_out_stall,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // The output register can take a result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_serve) begin
                        n_state = i_stat.empty ? S_DONE : S_SRV_RD;
                    end else begin
                        n_state = i_stat.full ? S_DONE : S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                n_state = i_stat.j_zero ? S_DONE : S_INS_CMP;
            end
            S_INS_CMP: begin
                n_state = i_stat.lower ? S_INS_RD : S_DONE;
            end
            S_SRV_RD: begin
                n_state = S_SRV_CMP;
            end
            S_SRV_CMP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_INS_RD: begin
                if (i_stat.j_zero) begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.push   = 1'b1;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_tail = 1'b1;
                end
            end
            S_INS_CMP: begin
                if (i_stat.lower) begin
                    o_cmd.wr_move   = 1'b1;
                    o_cmd.step_down = 1'b1;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.push   = 1'b1;
                end
            end
            S_SRV_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_SRV_CMP: begin
                o_cmd.pop = 1'b1;
            end
            S_DONE: begin
                o_cmd.publish = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Output valid and input stall.
    always_comb begin
        n_out_valid = o_cmd.publish || (r_out_valid && i_out_stall);
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
    end

endmodule

// ===== hdl/spq_dp.sv =====
// Datapath of the stable priority queue: slot RAM, pointers, counters and result registers.
module spq_dp import spq_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 16,
    parameter int LEVELS    = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TAG_WIDTH + PRIO_W;

    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_peak;
    logic [CW-1:0]        r_j;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [PRIO_W-1:0]    r_prio;
    logic [1:0]           r_status;
    logic [TAG_WIDTH-1:0] r_stag;
    logic [PRIO_W-1:0]    r_sprio;
    t_out_item            r_out;

    logic [TAG_WIDTH+TAG_PORT_W-1:0]  tag_in_ext;
    logic [TAG_WIDTH-1:0]             tag_in;
    logic [PRIO_W-1:0]                prio_sat;
    logic [TAG_WIDTH+TAG_PORT_W-1:0]  stag_ext;
    logic [CW+LEN_PORT_W-1:0]         count_ext;
    logic [CW+LEN_PORT_W-1:0]         peak_ext;
    logic [CW-1:0]                    rd_logical;
    logic [CW:0]                      rd_sum;
    logic [CW:0]                      wr_sum;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic [EW-1:0]                    wr_data;
    logic [EW-1:0]                    rd_data;
    logic [CW-1:0]                    count_inc;
    logic [1:0]                       load_status;

    // Input tag kept to TAG_WIDTH bits, priority saturated to the top level.
    always_comb begin
        tag_in_ext = (TAG_WIDTH + TAG_PORT_W)'(i_in_data.entry_tag);
        tag_in     = tag_in_ext[TAG_WIDTH-1:0];
        if (int'(i_in_data.entry_priority) > LEVELS - 1) begin
            prio_sat = PRIO_W'(LEVELS - 1);
        end else begin
            prio_sat = i_in_data.entry_priority;
        end
    end

    // Queue status toward the controller.
    always_comb begin
        o_stat.in_serve = (i_in_data.op == OP_SERVE);
        o_stat.full     = (r_count == CW'(DEPTH));
        o_stat.empty    = (r_count == '0);
        o_stat.j_zero   = (r_j == '0);
        o_stat.lower    = (rd_data[PRIO_W-1:0] < r_prio);
    end

    // Early status of an item, known when it is taken.
    always_comb begin
        if (i_in_data.op == OP_SERVE) begin
            load_status = o_stat.empty ? ST_EMPTY : ST_SERVED;
        end else begin
            load_status = o_stat.full ? ST_FULL : ST_INSERTED;
        end
    end

    // Logical slot to physical address: slot 0 sits at the head of a ring.
    always_comb begin
        rd_logical = i_cmd.rd_tail ? (r_j - CW'(1)) : '0;
        rd_sum     = (CW + 1)'(r_head) + (CW + 1)'(rd_logical);
        wr_sum     = (CW + 1)'(r_head) + (CW + 1)'(r_j);
        if (rd_sum >= (CW + 1)'(DEPTH)) begin
            rd_sum = rd_sum - (CW + 1)'(DEPTH);
        end
        if (wr_sum >= (CW + 1)'(DEPTH)) begin
            wr_sum = wr_sum - (CW + 1)'(DEPTH);
        end
        rd_addr = rd_sum[AW-1:0];
        wr_addr = wr_sum[AW-1:0];
        wr_data = i_cmd.wr_new ? {r_tag, r_prio} : rd_data;
    end

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_new || i_cmd.wr_move),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign count_inc = r_count + CW'(1);

    // Head, occupancy and peak.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_peak  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_count <= count_inc;
                if (count_inc > r_peak) begin
                    r_peak <= count_inc;
                end
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                if (r_head == AW'(DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + AW'(1);
                end
            end
        end
    end

    // Item registers and the insert walk position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag    <= tag_in;
            r_prio   <= prio_sat;
            r_status <= load_status;
            r_j      <= r_count;
            r_stag   <= '0;
            r_sprio  <= '0;
        end else begin
            if (i_cmd.step_down) begin
                r_j <= r_j - CW'(1);
            end
            if (i_cmd.pop) begin
                r_stag  <= rd_data[EW-1:PRIO_W];
                r_sprio <= rd_data[PRIO_W-1:0];
            end
        end
    end

    // Result fields folded to the port widths.
    always_comb begin
        stag_ext  = (TAG_WIDTH + TAG_PORT_W)'(r_stag);
        count_ext = (CW + LEN_PORT_W)'(r_count);
        peak_ext  = (CW + LEN_PORT_W)'(r_peak);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out.status          <= r_status;
            r_out.served_tag      <= stag_ext[TAG_PORT_W-1:0];
            r_out.served_priority <= r_sprio;
            r_out.queue_length    <= count_ext[LEN_PORT_W-1:0];
            r_out.peak_length     <= peak_ext[LEN_PORT_W-1:0];
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== hdl/stable_priority_queue_core.sv =====
// Stable priority queue: up to DEPTH entries, served highest priority first and
// first in, first out within a priority level. Entries live in a ring buffer in one
// RAM with a registered read port; a serve advances the head, and an insert walks
// from the tail toward the head, moving each lower-priority entry one slot back
// until it finds the place of the new entry. One item is in work at a time. A
// serve reads the head slot and then captures it, a refused insert or a serve on
// an empty queue goes straight to its result, and an insert reads and compares
// each entry it passes in a read-then-write loop over the RAM, then writes the new
// entry behind the first entry it does not pass, or at the head. A result waits
// in an output register, so the next item is taken while the previous result is
// still stalled. No clearing pass is needed after reset.
module stable_priority_queue_core import spq_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 16,
    parameter int LEVELS    = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    spq_dp #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH),
        .LEVELS    (LEVELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks of the stable priority queue and their binding to the top level.
`include "stable_priority_queue_core_macros.svh"

module spq_checker import spq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // Reset empties the output register.
    `SPQ_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A stalled result holds until its transfer.
    `SPQ_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "stalled result changed")

    // An accepted item keeps the input closed for at least the next cycle.
    `SPQ_ASSERT(a_one_item, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "second item taken while one is in work")

    // Only a successful serve carries a served entry.
    `SPQ_ASSERT(a_served_zero, i_clk, i_rst_n, (o_out_valid && (o_out_data.status != ST_SERVED)) |-> ((o_out_data.served_tag == '0) && (o_out_data.served_priority == '0)), "served fields set without a serve")

    // A serve on an empty queue leaves it empty.
    `SPQ_ASSERT(a_empty_len, i_clk, i_rst_n, (o_out_valid && (o_out_data.status == ST_EMPTY)) |-> (o_out_data.queue_length == '0), "empty serve with nonzero length")

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/stable_priority_queue_core_tb.sv =====
// Self-checking testbench for the stable priority queue core.
module stable_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int QDEPTH     = 16;
    localparam logic [PRIO_W-1:0] PRIO_TOP = 2'd2;
    localparam int PRINT_CAP  = 40;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Idle rates of the two sides, in percent of cycles.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Shadow copy of the queue contents, slot 0 is the head.
    logic [TAG_PORT_W-1:0] shadow_tag [QDEPTH];
    logic [PRIO_W-1:0]     shadow_prio[QDEPTH];
    int                    shadow_count = 0;
    int                    shadow_peak = 0;

    // Outcomes predicted for accepted items, oldest first.
    t_out_item awaited_outcomes[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int outcomes_checked = 0;
    int refused_inserts = 0;
    int empty_serves = 0;

    stable_priority_queue_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // The receiver stalls at random at the current rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Applies one item to the shadow queue and returns the outcome it must produce.
    function automatic t_out_item shadow_queue_step(input t_in_item item);
        t_out_item         res;
        logic [PRIO_W-1:0] prio;
        int                pos;
        int                i;
        res = '0;
        // Priorities past the top level saturate to it.
        prio = (item.entry_priority > PRIO_TOP) ? PRIO_TOP : item.entry_priority;
        if (item.op == OP_INSERT) begin
            if (shadow_count >= QDEPTH) begin
                res.status = ST_FULL;
                refused_inserts++;
            end else begin
                // The new entry goes ahead of the first entry with lower priority.
                pos = shadow_count;
                for (i = shadow_count - 1; i >= 0; i--) begin
                    if (prio > shadow_prio[i])
                        pos = i;
                end
                for (i = shadow_count; i > pos; i--) begin
                    shadow_tag[i]  = shadow_tag[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_tag[pos]  = item.entry_tag;
                shadow_prio[pos] = prio;
                shadow_count++;
                if (shadow_count > shadow_peak)
                    shadow_peak = shadow_count;
                res.status = ST_INSERTED;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
                empty_serves++;
            end else begin
                res.served_tag      = shadow_tag[0];
                res.served_priority = shadow_prio[0];
                for (i = 0; i + 1 < shadow_count; i++) begin
                    shadow_tag[i]  = shadow_tag[i+1];
                    shadow_prio[i] = shadow_prio[i+1];
                end
                shadow_count--;
                res.status = ST_SERVED;
            end
        end
        res.queue_length = LEN_PORT_W'(shadow_count);
        res.peak_length  = LEN_PORT_W'(shadow_peak);
        return res;
    endfunction

    // Sends one item, idling first at the sender rate, and records its outcome.
    // Valid stays high after the transfer so back-to-back items need no toggle.
    task automatic send_item(input t_in_item item);
        t_out_item outcome;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        outcome = shadow_queue_step(item);
        awaited_outcomes.insert(awaited_outcomes.size(), outcome);
        items_sent++;
    endtask

    // Drops valid and waits until every predicted outcome has arrived.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic op, input logic [TAG_PORT_W-1:0] tag,
                                           input logic [PRIO_W-1:0] prio);
        t_in_item item;
        item.op             = op;
        item.entry_tag      = tag;
        item.entry_priority = prio;
        return item;
    endfunction

    // Compare each output transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = awaited_outcomes.pop_front();
                outcomes_checked++;
                if (o_out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_out_data.status, want.status));
                if (o_out_data.served_tag !== want.served_tag)
                    report_mismatch($sformatf("served_tag got %h want %h",
                                              o_out_data.served_tag, want.served_tag));
                if (o_out_data.served_priority !== want.served_priority)
                    report_mismatch($sformatf("served_priority got %0d want %0d",
                                              o_out_data.served_priority,
                                              want.served_priority));
                if (o_out_data.queue_length !== want.queue_length)
                    report_mismatch($sformatf("queue_length got %0d want %0d",
                                              o_out_data.queue_length, want.queue_length));
                if (o_out_data.peak_length !== want.peak_length)
                    report_mismatch($sformatf("peak_length got %0d want %0d",
                                              o_out_data.peak_length, want.peak_length));
            end
        end
    end

    // A serve right after reset finds the queue empty; its ignored fields are all ones.
    task automatic test_serve_empty;
        send_item(make_item(OP_SERVE, 16'hFFFF, 2'd3));
    endtask

    // Fill the queue with every priority, the out-of-range one too, and extreme tags.
    task automatic test_fill_mixed_priorities;
        logic [PRIO_W-1:0] prio_seq[QDEPTH];
        int                k;
        prio_seq = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd0,
                     2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
        send_item(make_item(OP_INSERT, 16'h0000, prio_seq[0]));
        send_item(make_item(OP_INSERT, 16'hFFFF, prio_seq[1]));
        for (k = 2; k < QDEPTH; k++)
            send_item(make_item(OP_INSERT, 16'hA5A5 ^ TAG_PORT_W'(k * 16'h1111), prio_seq[k]));
    endtask

    // An insert into the full queue is refused; then the head is served a few times.
    task automatic test_refusal_and_serves;
        int k;
        send_item(make_item(OP_INSERT, 16'h1234, 2'd2));
        for (k = 0; k < 5; k++)
            send_item(make_item(OP_SERVE, 16'h0000, 2'd0));
        drain();
    endtask

    // Random traffic in runs that lean toward inserts or serves, so the queue
    // swings between full and empty again and again.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_items);
        int                    k;
        int                    run_left;
        int                    insert_pct;
        logic [PRIO_W-1:0]     prio;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        run_left = 0;
        insert_pct = 50;
        for (k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(48, 8);
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            run_left--;
            prio = ($urandom_range(99) < 8) ? 2'd3 : PRIO_W'($urandom_range(2));
            send_item(make_item(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_SERVE,
                                TAG_PORT_W'($urandom), prio));
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_serve_empty();
        test_fill_mixed_priorities();
        test_refusal_and_serves();
        test_random_traffic(21, 46, 600);
        test_random_traffic(46, 21, 600);
        test_random_traffic(0, 0, 600);

        // Let any stray result show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (awaited_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));

        $display("Covered %0d items and %0d results, %0d refused inserts, %0d empty serves.",
                 items_sent, outcomes_checked, refused_inserts, empty_serves);
        $display("Mismatches: %0d.", mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== stable_priority_queue_core.f =====
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/stable_priority_queue_core.sv
hdl/spq_checker.sv
tb/sv/stable_priority_queue_core_tb.sv
